/* rtl/ehls_pkg.sv */
// Shared types, codes and arithmetic helpers for the expanding/halving line search.
// Used by every module of the block; depends on nothing else.
package ehls_pkg;

  // Field widths
  localparam int LenW     = 32;
  localparam int ValW     = 48;
  localparam int TotW     = 16;
  localparam int SrchW    = 8;
  localparam int CmdW     = 2;
  localparam int KindW    = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  // Stream packing
  localparam int InDataW   = 128;
  localparam int OutFieldW = LenW + 1 + ValW + LenW + TotW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // Reciprocal of ten: floor(x * Div10Recip / 2^Div10Shift) == x / 10 for 32-bit x
  localparam logic [31:0] Div10Recip = 32'hCCCC_CCCD;
  localparam int          Div10Shift = 35;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LENGTH       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TRIALS_TOTAL = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TRIALS_SRCH  = 2'd3;

  // Register reset values
  localparam logic [LenW-1:0]  MaxLengthRst   = 32'd65536;
  localparam logic [LenW-1:0]  MinLengthRst   = 32'd64;
  localparam logic [TotW-1:0]  MaxTotalRst    = 16'd0;
  localparam logic [SrchW-1:0] MaxPerSrchRst  = 8'd12;

  typedef enum logic [CmdW-1:0] {
    CMD_START  = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_TRIAL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ACK   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_GROW   = 2'd1,
    PH_SHRINK = 2'd2
  } phase_e;

  typedef struct packed {
    logic [LenW-1:0]  max_length;
    logic [LenW-1:0]  min_length;
    logic [TotW-1:0]  max_trials_total;
    logic [SrchW-1:0] max_trials_per_search;
  } cfg_t;

  typedef struct packed {
    phase_e                  phase;
    logic [LenW-1:0]         trial_length;
    logic [LenW-1:0]         accepted_sum;
    logic signed [ValW-1:0]  best_so_far;
    logic [TotW-1:0]         total_trials;
    logic [SrchW-1:0]        search_trials;
  } state_t;

  typedef struct packed {
    logic [CmdW-1:0]         command;
    logic [LenW-1:0]         start_length;
    logic signed [ValW-1:0]  initial_best;
    logic signed [ValW-1:0]  objective_value;
  } item_t;

  typedef struct packed {
    kind_e                   result_kind;
    logic [LenW-1:0]         step_length;
    logic                    last_accepted;
    logic signed [ValW-1:0]  best_value;
    logic [LenW-1:0]         next_start_length;
    logic [TotW-1:0]         trials_used;
  } result_t;

  // Grow a length by exactly 1.1 (rounded down) and cap it at max_len.
  // len * 11 / 10 == len + len / 10 for integer len.
  function automatic logic [LenW-1:0] grow_length(input logic [LenW-1:0] len,
                                                   input logic [LenW-1:0] max_len);
    logic [63:0]     prod;
    logic [LenW:0]   grown;
    prod  = 64'(len) * 64'(Div10Recip);
    grown = {1'b0, len} + (LenW + 1)'(prod >> Div10Shift);
    if (grown > {1'b0, max_len}) begin
      return max_len;
    end
    return grown[LenW-1:0];
  endfunction

endpackage

/* rtl/ehls_cfg_regs.sv */
// Configuration register file for the line search: four write-only registers.
// Depends on ehls_pkg for register indexes, reset values and cfg_t.
module ehls_cfg_regs
  import ehls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index on a write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_LENGTH:       cfg_d.max_length            = cfg_wdata_i[LenW-1:0];
        CFG_MIN_LENGTH:       cfg_d.min_length            = cfg_wdata_i[LenW-1:0];
        CFG_MAX_TRIALS_TOTAL: cfg_d.max_trials_total      = cfg_wdata_i[TotW-1:0];
        CFG_MAX_TRIALS_SRCH:  cfg_d.max_trials_per_search = cfg_wdata_i[SrchW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_length            <= MaxLengthRst;
      cfg_q.min_length            <= MinLengthRst;
      cfg_q.max_trials_total      <= MaxTotalRst;
      cfg_q.max_trials_per_search <= MaxPerSrchRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/ehls_step.sv */
// Combinational next-state and result logic for one item of the line search.
// Depends on ehls_pkg for the state, item, result and config types.
module ehls_step
  import ehls_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  state_t          nxt;
  kind_e           kind;
  logic            accepted;
  logic            run_advance;
  logic            limits_ok;
  logic [LenW:0]   sum_wide;
  logic [LenW-1:0] grown;

  // Candidate values that depend only on the current state and the configuration
  assign sum_wide = {1'b0, state_i.accepted_sum} + {1'b0, state_i.trial_length};
  assign grown    = grow_length(state_i.trial_length, cfg_i.max_length);

  always_comb begin
    nxt         = state_i;
    kind        = KIND_ACK;
    accepted    = 1'b0;
    run_advance = 1'b0;
    limits_ok   = 1'b0;

    // Apply the command
    unique case (item_i.command)
      CMD_START: begin
        nxt.trial_length  = (item_i.start_length > cfg_i.max_length) ?
                            cfg_i.max_length : item_i.start_length;
        nxt.best_so_far   = item_i.initial_best;
        nxt.accepted_sum  = '0;
        nxt.search_trials = '0;
        nxt.phase         = PH_GROW;
        run_advance       = 1'b1;
      end
      CMD_REPORT: begin
        if (state_i.phase != PH_IDLE) begin
          // Saturating trial counters
          if (state_i.total_trials != '1) begin
            nxt.total_trials = state_i.total_trials + TotW'(1);
          end
          if (state_i.search_trials != '1) begin
            nxt.search_trials = state_i.search_trials + SrchW'(1);
          end
          // Accept an improvement and add its length to the sum
          if (item_i.objective_value > state_i.best_so_far) begin
            accepted         = 1'b1;
            nxt.best_so_far  = item_i.objective_value;
            nxt.accepted_sum = sum_wide[LenW] ? '1 : sum_wide[LenW-1:0];
          end
          // Grow on improvement, else halve and shrink; shrinking always halves
          if (state_i.phase == PH_GROW) begin
            if (accepted) begin
              nxt.trial_length = grown;
            end else begin
              nxt.trial_length = state_i.trial_length >> 1;
              nxt.phase        = PH_SHRINK;
            end
          end else begin
            nxt.trial_length = state_i.trial_length >> 1;
          end
          run_advance = 1'b1;
        end
      end
      CMD_CLEAR: begin
        nxt.total_trials = '0;
      end
      default: ;
    endcase

    // Decide whether to ask for another trial or finish
    if (run_advance) begin
      limits_ok = (nxt.total_trials < cfg_i.max_trials_total) &&
                  (nxt.search_trials < cfg_i.max_trials_per_search);
      if (nxt.phase == PH_GROW && limits_ok) begin
        kind = KIND_TRIAL;
      end else begin
        if (nxt.phase == PH_GROW) begin
          nxt.trial_length = nxt.trial_length >> 1;
          nxt.phase        = PH_SHRINK;
        end
        if (nxt.trial_length > cfg_i.min_length && limits_ok) begin
          kind = KIND_TRIAL;
        end else begin
          nxt.phase = PH_IDLE;
          kind      = KIND_DONE;
        end
      end
    end
  end

  assign state_o                    = nxt;
  assign result_o.result_kind       = kind;
  assign result_o.step_length       = (kind == KIND_TRIAL) ? nxt.trial_length : '0;
  assign result_o.last_accepted     = accepted;
  assign result_o.best_value        = nxt.best_so_far;
  assign result_o.next_start_length = nxt.accepted_sum;
  assign result_o.trials_used       = nxt.total_trials;

endmodule

/* rtl/expanding_halving_line_search.sv */
// Step-length controller for an expanding-and-halving line search. Each beat
// in (start, report or clear) gives exactly one beat out: the beat is captured
// in an input register, then one pass of logic updates the search state and
// fills the result register. A new beat is taken every cycle while the result
// side does not stall; the per-item loop is the state update, whose longest
// path is the 32x32 reciprocal multiply of the 1.1 growth and the cap compare.
// Lengths are unsigned Q16.16, objective values signed Q32.16. Write the
// configuration registers only while no beat is in flight.
module expanding_halving_line_search
  import ehls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Command stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: start_length[31:0], initial_best[79:32], objective_value[127:80]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: command[1:0]
  input  logic [CmdW-1:0]     s_axis_tuser,
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: step_length[31:0], last_accepted[32], best_value[80:33],
  //        next_start_length[112:81], trials_used[128:113], zero pad above
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser: result_kind[1:0]
  output logic [KindW-1:0]    m_axis_tuser
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   item_q;
  logic    in_valid_q, in_valid_d;
  state_t  state_q, state_d;
  result_t res_d, res_q;
  logic    out_valid_q, out_valid_d;
  logic    in_fire;
  logic    advance;

  ehls_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Unpack the incoming beat
  assign in_item.command         = s_axis_tuser;
  assign in_item.start_length    = s_axis_tdata[LenW-1:0];
  assign in_item.initial_best    = s_axis_tdata[LenW+ValW-1:LenW];
  assign in_item.objective_value = s_axis_tdata[LenW+2*ValW-1:LenW+ValW];

  // Handshake: the held beat moves on when the result register is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  ehls_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Control and search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
      state_q.phase         <= PH_IDLE;
      state_q.trial_length  <= '0;
      state_q.accepted_sum  <= '0;
      state_q.best_so_far   <= '0;
      state_q.total_trials  <= '0;
      state_q.search_trials <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Pack the result beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.result_kind;
  assign m_axis_tdata  = OutDataW'({res_q.trials_used,
                                    res_q.next_start_length,
                                    res_q.best_value,
                                    res_q.last_accepted,
                                    res_q.step_length});

endmodule

/* bench/tb_expanding_halving_line_search.sv */
// Testbench for expanding_halving_line_search: sends command beats with random gaps
// and back-pressure, predicts each result beat and checks it field by field.
// Depends on ehls_pkg and the RTL of the block.
module tb_expanding_halving_line_search;
  import ehls_pkg::*;

  localparam int MaxCycles = 400000;
  localparam int Settle    = 8;
  localparam int RandBeats = 360;
  localparam int HoldOff   = 80;
  localparam int GrowNum   = 11;
  localparam int GrowDen   = 10;

  // Command code the block must ignore
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  localparam logic [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};
  localparam logic [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // tdata: start_length[31:0], initial_best[79:32], objective_value[127:80]
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // tuser: command[1:0]
  logic [CmdW-1:0]     s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // tdata: step_length[31:0], last_accepted[32], best_value[80:33],
  //        next_start_length[112:81], trials_used[128:113]
  logic [OutDataW-1:0] m_axis_tdata;
  // tuser: result_kind[1:0]
  logic [KindW-1:0]    m_axis_tuser;

  // Predicted search state and limits
  cfg_t    limits;
  state_t  srch;
  result_t pending_steps[$];

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold = 0;
  int fails = 0;
  int cycles = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int searches = 0;
  int finished = 0;
  int accepts = 0;
  int reg_writes = 0;

  expanding_halving_line_search u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("tb_expanding_halving_line_search NOT OK");
      $finish;
    end
  end

  function automatic void reset_model();
    limits.max_length            = MaxLengthRst;
    limits.min_length            = MinLengthRst;
    limits.max_trials_total      = MaxTotalRst;
    limits.max_trials_per_search = MaxPerSrchRst;
    srch       = '0;
    srch.phase = PH_IDLE;
  endfunction

  function automatic bit trials_left();
    return srch.total_trials < limits.max_trials_total &&
           srch.search_trials < limits.max_trials_per_search;
  endfunction

  // Pick the next action: another trial, or finish the search
  function automatic kind_e next_action();
    if (srch.phase == PH_GROW) begin
      if (trials_left()) return KIND_TRIAL;
      srch.trial_length = srch.trial_length >> 1;
      srch.phase = PH_SHRINK;
    end
    if (srch.trial_length > limits.min_length && trials_left()) return KIND_TRIAL;
    srch.phase = PH_IDLE;
    return KIND_DONE;
  endfunction

  // Advance the predicted search by one command beat and return its result
  function automatic result_t search_step(input item_t it);
    result_t     r;
    logic [63:0] wide;
    r = '0;
    r.result_kind = KIND_ACK;
    case (it.command)
      CMD_START: begin
        srch.trial_length  = (it.start_length > limits.max_length) ?
                             limits.max_length : it.start_length;
        srch.best_so_far   = it.initial_best;
        srch.accepted_sum  = '0;
        srch.search_trials = '0;
        srch.phase         = PH_GROW;
        r.result_kind      = next_action();
      end
      CMD_REPORT: begin
        if (srch.phase != PH_IDLE) begin
          if (srch.total_trials != '1) srch.total_trials = srch.total_trials + 1'b1;
          if (srch.search_trials != '1) srch.search_trials = srch.search_trials + 1'b1;
          if ($signed(it.objective_value) > $signed(srch.best_so_far)) begin
            r.last_accepted  = 1'b1;
            srch.best_so_far = it.objective_value;
            wide = 64'(srch.accepted_sum) + 64'(srch.trial_length);
            srch.accepted_sum = (wide > 64'(32'hFFFF_FFFF)) ? '1 : wide[LenW-1:0];
          end
          if (srch.phase == PH_GROW) begin
            if (r.last_accepted) begin
              wide = 64'(srch.trial_length) * GrowNum / GrowDen;
              srch.trial_length = (wide > 64'(limits.max_length)) ?
                                  limits.max_length : wide[LenW-1:0];
            end else begin
              srch.trial_length = srch.trial_length >> 1;
              srch.phase = PH_SHRINK;
            end
          end else begin
            srch.trial_length = srch.trial_length >> 1;
          end
          r.result_kind = next_action();
        end
      end
      CMD_CLEAR: begin
        srch.total_trials = '0;
      end
      default: begin
      end
    endcase
    r.step_length       = (r.result_kind == KIND_TRIAL) ? srch.trial_length : '0;
    r.best_value        = srch.best_so_far;
    r.next_start_length = srch.accepted_sum;
    r.trials_used       = srch.total_trials;
    return r;
  endfunction

  function automatic result_t unpack_result(input logic [OutDataW-1:0] d,
                                            input logic [KindW-1:0] u);
    result_t r;
    r.result_kind       = kind_e'(u);
    r.step_length       = d[31:0];
    r.last_accepted     = d[32];
    r.best_value        = d[80:33];
    r.next_start_length = d[112:81];
    r.trials_used       = d[128:113];
    return r;
  endfunction

  function automatic logic [ValW-1:0] random_value();
    return ValW'({$urandom(), $urandom()});
  endfunction

  // Objective close to the best, so about half the reports improve
  function automatic logic [ValW-1:0] near_best();
    return srch.best_so_far + ValW'($urandom_range(0, 4000)) - ValW'(2000);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      fails++;
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : check_results
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = unpack_result(m_axis_tdata, m_axis_tuser);
      results_seen++;
      if (pending_steps.size() == 0) begin
        $error("result beat with no prediction waiting: kind %0d", got.result_kind);
        fails++;
      end else begin
        want = pending_steps.pop_front();
        if (want.result_kind == KIND_DONE) finished++;
        if (want.last_accepted) accepts++;
        check_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
        check_field("step_length", 64'(want.step_length), 64'(got.step_length));
        check_field("last_accepted", 64'(want.last_accepted), 64'(got.last_accepted));
        check_field("best_value", 64'(want.best_value), 64'(got.best_value));
        check_field("next_start_length", 64'(want.next_start_length),
                    64'(got.next_start_length));
        check_field("trials_used", 64'(want.trials_used), 64'(got.trials_used));
      end
    end
  end

  // Result side: long hold-off on request, otherwise random stalls unless rx_calm is set
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready = 1'b0;
    end else if (rx_hold > 0) begin
      m_axis_tready = 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_axis_tready = rx_calm || ($urandom_range(0, 99) >= 21);
    end
  end

  // Offer one command beat and wait until the block takes it
  task automatic send_beat(input logic [CmdW-1:0] cmd, input logic [LenW-1:0] len,
                           input logic [ValW-1:0] best, input logic [ValW-1:0] obj);
    item_t it;
    it.command         = cmd;
    it.start_length    = len;
    it.initial_best    = best;
    it.objective_value = obj;
    @(negedge clk_i);
    while (!tx_calm && $urandom_range(0, 99) < 21) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {it.objective_value, it.initial_best, it.start_length};
    s_axis_tuser  = it.command;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_steps.push_back(search_step(it));
    beats_sent++;
    if (cmd == CMD_START) searches++;
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_MAX_LENGTH:       limits.max_length = val;
      CFG_MIN_LENGTH:       limits.min_length = val;
      CFG_MAX_TRIALS_TOTAL: limits.max_trials_total = TotW'(val);
      default:              limits.max_trials_per_search = SrchW'(val);
    endcase
    reg_writes++;
  endtask

  task automatic report(input logic [ValW-1:0] obj);
    send_beat(CMD_REPORT, $urandom(), random_value(), obj);
  endtask

  // Start one search and feed it mostly well-formed reports until it ends
  task automatic run_search();
    logic [LenW-1:0] len;
    int              pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) len = $urandom();
    else if (pick < 8) len = $urandom_range(0, 32'h3_0000);
    else if (pick == 8) len = '0;
    else len = '1;
    send_beat(CMD_START, len, ($urandom_range(0, 1) != 0) ? random_value() :
              ValW'($urandom_range(0, 2000)) - ValW'(1000), random_value());
    while (srch.phase != PH_IDLE) begin
      pick = $urandom_range(0, 99);
      if (pick < 84) report(near_best());
      else if (pick < 90) report(random_value());
      else if (pick < 94) send_beat(CMD_CLEAR, $urandom(), random_value(), random_value());
      else if (pick < 97) send_beat(CMD_UNUSED, $urandom(), random_value(), random_value());
      else send_beat(CMD_START, $urandom(), random_value(), random_value());
    end
    // Occasionally report into an idle block
    if ($urandom_range(0, 3) == 0) report(random_value());
  endtask

  // Reset limits allow no trial at all; ignored commands only acknowledge
  task automatic test_reset_limits();
    report(ValMax);
    send_beat(CMD_START, 32'h0002_0000, 48'd5, '0);
    send_beat(CMD_CLEAR, '1, ValMin, ValMax);
    send_beat(CMD_UNUSED, '1, ValMax, ValMin);
    drain();
  endtask

  // Full searches through grow, shrink, restart, clear and both limits
  task automatic test_directed_search();
    write_reg(CFG_MAX_TRIALS_TOTAL, 32'hFFFF);
    write_reg(CFG_MAX_TRIALS_SRCH, 32'd12);
    write_reg(CFG_MAX_LENGTH, 32'h0001_0000);
    write_reg(CFG_MIN_LENGTH, 32'd64);
    send_beat(CMD_START, '1, ValMin, '0);
    report(ValMax);
    report(ValMax);
    send_beat(CMD_CLEAR, '0, '0, '0);
    report(ValMin);
    // Restart mid-search with zero length: trials at length zero
    send_beat(CMD_START, '0, '0, '0);
    report(48'd1);
    report(48'd0);
    report(48'd7);
    drain();
    // Sum of accepted lengths saturates
    write_reg(CFG_MAX_LENGTH, '1);
    send_beat(CMD_START, '1, ValMin, '0);
    report(48'd1);
    report(48'd2);
    while (srch.phase != PH_IDLE) report(near_best());
    drain();
    // Total limit ends searches, clear lets them run again
    write_reg(CFG_MAX_TRIALS_TOTAL, 32'd3);
    send_beat(CMD_START, 32'h0000_8000, '0, '0);
    while (srch.phase != PH_IDLE) report(near_best());
    send_beat(CMD_START, 32'h0000_8000, '0, '0);
    send_beat(CMD_CLEAR, '0, '0, '0);
    send_beat(CMD_START, 32'h0000_8000, '0, '0);
    while (srch.phase != PH_IDLE) report(near_best());
    drain();
    write_reg(CFG_MAX_TRIALS_TOTAL, 32'hFFFF);
  endtask

  // Hold the result side off while the sender keeps offering beats
  task automatic test_back_pressure();
    int first;
    first   = beats_sent;
    tx_calm = 1'b1;
    @(negedge clk_i);
    rx_hold = HoldOff;
    while (beats_sent - first < 30) run_search();
    drain();
    tx_calm = 1'b0;
  endtask

  // Draw a new set of limits, extremes included
  task automatic pick_limits();
    int pick;
    if ($urandom_range(0, 9) < 6) begin
      pick = $urandom_range(0, 5);
      write_reg(CFG_MAX_LENGTH, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1 :
                (pick == 2) ? 32'hFFFF_FFFF : (pick == 3) ? 32'h0001_0000 :
                (pick == 4) ? $urandom() : $urandom_range(0, 32'h4_0000));
    end
    if ($urandom_range(0, 9) < 6) begin
      pick = $urandom_range(0, 3);
      write_reg(CFG_MIN_LENGTH, (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF :
                (pick == 2) ? 32'd64 : $urandom_range(0, 32'h1_0000));
    end
    if ($urandom_range(0, 9) < 5) begin
      pick = $urandom_range(0, 9);
      write_reg(CFG_MAX_TRIALS_TOTAL, (pick < 5) ? 32'hFFFF : (pick < 8) ?
                $urandom_range(20, 500) : (pick == 8) ? 32'd0 : $urandom());
    end
    if ($urandom_range(0, 9) < 6) begin
      pick = $urandom_range(0, 5);
      write_reg(CFG_MAX_TRIALS_SRCH, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1 :
                (pick == 2) ? 32'd255 : $urandom_range(1, 20));
    end
  endtask

  // Random searches in phases of changing limits; the first phase never idles
  task automatic test_random_searches();
    int first;
    first   = beats_sent;
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    while (beats_sent - first < RandBeats) begin
      if (beats_sent - first > 120) begin
        tx_calm = 1'b0;
        rx_calm = 1'b0;
      end
      repeat ($urandom_range(3, 6)) run_search();
      drain();
      pick_limits();
    end
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_limits();
    test_directed_search();
    test_back_pressure();
    test_random_searches();
    drain();
    if (pending_steps.size() != 0) begin
      $error("%0d predicted results never arrived", pending_steps.size());
      fails++;
    end
    $display("Sent %0d command beats over %0d searches, checked %0d results", beats_sent,
             searches, results_seen);
    $display("Saw %0d finished searches and %0d accepted reports after %0d limit writes",
             finished, accepts, reg_writes);
    if (fails == 0) begin
      $display("tb_expanding_halving_line_search OK");
    end else begin
      $display("tb_expanding_halving_line_search NOT OK");
    end
    $finish;
  end

endmodule
